// ----- sv/pdss_pkg.sv -----
// Constants and state encoding for the PLL divider setting search core.
package pdss_pkg;

    // Oscillator and range limits in kHz, and the lowest multiplier
    localparam logic [31:0] OSC_KHZ     = 32'd48000;
    localparam logic [31:0] HALF_OSC    = 32'd24000;
    localparam logic [31:0] OUT_MIN     = 32'd25000;
    localparam logic [31:0] OUT_MAX     = 32'd430000;
    localparam logic [31:0] VCO_MIN     = 32'd1600000;
    localparam logic [31:0] VCO_MAX     = 32'd3200000;
    localparam logic [9:0]  M_MIN       = 10'h040;

    // Loop bounds
    localparam logic [3:0]  CODE_LAST   = 4'd15;   // post divider 32
    localparam logic [2:0]  S_LAST      = 3'd6;
    // 48000/P lies in 6000..25000 only for P from 2 to 8
    localparam logic [5:0]  P_FIRST     = 6'd2;
    localparam logic [5:0]  P_LAST      = 6'd8;

    // Reciprocals for division by constants:
    //   x/1000  = (x * KHZ_RECIP) >> 38, exact for any 32-bit x
    //   y/375   = (y * M_RECIP)   >> 27, exact for y below 2^18
    //   z/375   = (z * K_RECIP)   >> 33, exact for z below 2^24
    localparam logic [31:0] KHZ_RECIP   = 32'h10624DD3;
    localparam logic [31:0] M_RECIP     = 32'd357914;
    localparam logic [31:0] K_RECIP     = 32'd22906493;

    // Sequencer states
    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_KHZ     = 13'b0000000000010,
        ST_KHZ_CHK = 13'b0000000000100,
        ST_D       = 13'b0000000001000,
        ST_FOUT    = 13'b0000000010000,
        ST_S       = 13'b0000000100000,
        ST_P       = 13'b0000001000000,
        ST_T       = 13'b0000010000000,
        ST_M       = 13'b0000100000000,
        ST_R       = 13'b0001000000000,
        ST_K       = 13'b0010000000000,
        ST_K_WB    = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } t_state;

endpackage

// ----- sv/pll_divider_setting_search_core.sv -----
// Fractional PLL setting search: sequencer around one shared registered multiplier.
// One item is searched at a time; the next is taken once the sequencer is back in idle,
// while the previous result may still wait in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module pll_divider_setting_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] target_rate_hz
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] found, [4:1] post_div_code, [10:5] ref_div_p,
                                        // [20:11] mult_m, [23:21] shift_s, [38:24] frac_k
);

    pdss_pkg::t_state r_state, n_state;

    logic [31:0] r_rate;
    logic [22:0] r_khz;
    logic [3:0]  r_code;
    logic [18:0] r_fout;
    logic [2:0]  r_s;
    logic [21:0] r_fvco;
    logic [5:0]  r_p;
    logic [24:0] r_t;
    logic [9:0]  r_m;
    logic [15:0] r_rem;
    logic [14:0] r_k;
    logic        r_found;
    logic [63:0] r_prod;
    logic        r_out_valid;
    logic [39:0] r_out_data;

    logic [31:0] mul_a, mul_b;
    logic [5:0]  div_d;
    logic [24:0] fvco_c;
    logic [24:0] rem_c;
    logic        out_free;

    assign div_d    = {1'b0, r_code, 1'b0} + 6'd2;
    assign fvco_c   = {6'b0, r_fout} << r_s;
    assign rem_c    = r_t - r_prod[24:0];
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == pdss_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_state)
            pdss_pkg::ST_KHZ: begin
                mul_a = r_rate;
                mul_b = pdss_pkg::KHZ_RECIP;
            end
            pdss_pkg::ST_D: begin
                mul_a = {9'd0, r_khz};
                mul_b = {26'd0, div_d};
            end
            pdss_pkg::ST_P: begin
                mul_a = {10'd0, r_fvco};
                mul_b = {26'd0, r_p};
            end
            pdss_pkg::ST_T: begin
                // T/48000 = (T>>7)/375
                mul_a = {14'd0, r_prod[24:7]};
                mul_b = pdss_pkg::M_RECIP;
            end
            pdss_pkg::ST_M: begin
                mul_a = {22'd0, r_prod[36:27]};
                mul_b = pdss_pkg::OSC_KHZ;
            end
            pdss_pkg::ST_K: begin
                // R*65536/48000 = (R*512)/375
                mul_a = {7'd0, r_rem, 9'd0};
                mul_b = pdss_pkg::K_RECIP;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdss_pkg::ST_IDLE:    if (s_axis_tvalid) n_state = pdss_pkg::ST_KHZ;
            pdss_pkg::ST_KHZ:     n_state = pdss_pkg::ST_KHZ_CHK;
            pdss_pkg::ST_KHZ_CHK: n_state = pdss_pkg::ST_D;
            pdss_pkg::ST_D:       n_state = pdss_pkg::ST_FOUT;
            pdss_pkg::ST_FOUT: begin
                if ({3'd0, r_prod[28:0]} >= pdss_pkg::OUT_MIN &&
                    {3'd0, r_prod[28:0]} <= pdss_pkg::OUT_MAX) begin
                    n_state = pdss_pkg::ST_S;
                end else if (r_code == pdss_pkg::CODE_LAST) begin
                    n_state = pdss_pkg::ST_DONE;
                end else begin
                    n_state = pdss_pkg::ST_D;
                end
            end
            pdss_pkg::ST_S: begin
                if ({7'd0, fvco_c} >= pdss_pkg::VCO_MIN &&
                    {7'd0, fvco_c} <= pdss_pkg::VCO_MAX) begin
                    n_state = pdss_pkg::ST_P;
                end else if (r_s != pdss_pkg::S_LAST) begin
                    n_state = pdss_pkg::ST_S;
                end else if (r_code == pdss_pkg::CODE_LAST) begin
                    n_state = pdss_pkg::ST_DONE;
                end else begin
                    n_state = pdss_pkg::ST_D;
                end
            end
            pdss_pkg::ST_P:       n_state = pdss_pkg::ST_T;
            pdss_pkg::ST_T:       n_state = pdss_pkg::ST_M;
            pdss_pkg::ST_M:       n_state = pdss_pkg::ST_R;
            pdss_pkg::ST_R: begin
                // M never exceeds 533 here, so only the lower bound can fail
                if (r_m >= pdss_pkg::M_MIN && {7'd0, rem_c} < pdss_pkg::HALF_OSC) begin
                    n_state = pdss_pkg::ST_K;
                end else if (r_p != pdss_pkg::P_LAST) begin
                    n_state = pdss_pkg::ST_P;
                end else if (r_s != pdss_pkg::S_LAST) begin
                    n_state = pdss_pkg::ST_S;
                end else if (r_code == pdss_pkg::CODE_LAST) begin
                    n_state = pdss_pkg::ST_DONE;
                end else begin
                    n_state = pdss_pkg::ST_D;
                end
            end
            pdss_pkg::ST_K:       n_state = pdss_pkg::ST_K_WB;
            pdss_pkg::ST_K_WB:    n_state = pdss_pkg::ST_DONE;
            pdss_pkg::ST_DONE:    if (out_free) n_state = pdss_pkg::ST_IDLE;
            default:              n_state = pdss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdss_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pdss_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            pdss_pkg::ST_IDLE: begin
                r_rate  <= s_axis_tdata;
                r_found <= 1'b0;
            end
            pdss_pkg::ST_KHZ_CHK: begin
                r_khz  <= r_prod[60:38];
                r_code <= 4'd0;
            end
            pdss_pkg::ST_FOUT: begin
                r_fout <= r_prod[18:0];
                r_s    <= 3'd0;
                if (!({3'd0, r_prod[28:0]} >= pdss_pkg::OUT_MIN &&
                      {3'd0, r_prod[28:0]} <= pdss_pkg::OUT_MAX)) begin
                    r_code <= r_code + 4'd1;
                end
            end
            pdss_pkg::ST_S: begin
                r_fvco <= fvco_c[21:0];
                r_p    <= pdss_pkg::P_FIRST;
                if (!({7'd0, fvco_c} >= pdss_pkg::VCO_MIN &&
                      {7'd0, fvco_c} <= pdss_pkg::VCO_MAX)) begin
                    if (r_s != pdss_pkg::S_LAST) begin
                        r_s <= r_s + 3'd1;
                    end else begin
                        r_code <= r_code + 4'd1;
                    end
                end
            end
            pdss_pkg::ST_T: begin
                r_t <= r_prod[24:0];
            end
            pdss_pkg::ST_M: begin
                r_m <= r_prod[36:27];
            end
            pdss_pkg::ST_R: begin
                r_rem <= rem_c[15:0];
                if (!(r_m >= pdss_pkg::M_MIN && {7'd0, rem_c} < pdss_pkg::HALF_OSC)) begin
                    // advance p, then s, then the post divider
                    if (r_p != pdss_pkg::P_LAST) begin
                        r_p <= r_p + 6'd1;
                    end else if (r_s != pdss_pkg::S_LAST) begin
                        r_s <= r_s + 3'd1;
                    end else begin
                        r_code <= r_code + 4'd1;
                    end
                end
            end
            pdss_pkg::ST_K_WB: begin
                r_k     <= r_prod[47:33];
                r_found <= 1'b1;
            end
            pdss_pkg::ST_DONE: begin
                if (out_free) begin
                    if (r_found) begin
                        r_out_data <= {1'b0, r_k, r_s, r_m, r_p, r_code, 1'b1};
                    end else begin
                        r_out_data <= 40'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- test/pll_divider_setting_search_core_checker.sv -----
// Scoreboard for the PLL setting search core: predicts each search and checks each result.
`timescale 1ns / 1ps

module pll_divider_setting_search_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] target_rate_hz
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [0] found, [4:1] post_div_code, [10:5] ref_div_p,
                                        // [20:11] mult_m, [23:21] shift_s, [38:24] frac_k
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_found
);

    localparam logic [63:0] REF_KHZ_MIN = 64'd6000;
    localparam logic [63:0] REF_KHZ_MAX = 64'd25000;
    localparam int          REF_DIV_MAX = 63;
    localparam int          POST_DIV_MAX = 32;
    localparam logic [63:0] HZ_PER_KHZ  = 64'd1000;
    localparam logic [63:0] FRAC_SCALE  = 64'd65536;

    typedef struct packed {
        logic        found;
        logic [3:0]  post_div_code;
        logic [5:0]  ref_div_p;
        logic [9:0]  mult_m;
        logic [2:0]  shift_s;
        logic [14:0] frac_k;
    } t_pll_setting;

    t_pll_setting setting_q[$];

    // Walk post divider, VCO shift and reference divider in order; the first fit wins.
    function automatic t_pll_setting search_pll_setting(input logic [31:0] rate_hz);
        t_pll_setting res;
        logic [63:0]  khz;
        logic [63:0]  fout;
        logic [63:0]  fvco;
        logic [63:0]  fref;
        logic [63:0]  prod;
        logic [63:0]  mult;
        logic [63:0]  rem;
        res = '0;
        khz = {32'd0, rate_hz} / HZ_PER_KHZ;
        for (int d = 2; d <= POST_DIV_MAX; d += 2) begin
            fout = khz * 64'(d);
            if (fout > 64'(pdss_pkg::OUT_MAX) || fout < 64'(pdss_pkg::OUT_MIN))
                continue;
            for (int s = 0; s <= int'(pdss_pkg::S_LAST); s++) begin
                fvco = fout << s;
                if (fvco > 64'(pdss_pkg::VCO_MAX) || fvco < 64'(pdss_pkg::VCO_MIN))
                    continue;
                for (int p = 1; p <= REF_DIV_MAX; p++) begin
                    fref = 64'(pdss_pkg::OSC_KHZ) / 64'(p);
                    if (fref > REF_KHZ_MAX || fref < REF_KHZ_MIN)
                        continue;
                    prod = fvco * 64'(p);
                    mult = prod / 64'(pdss_pkg::OSC_KHZ);
                    if (mult < 64'(pdss_pkg::M_MIN) || mult > 64'h3FF)
                        continue;
                    rem = prod % 64'(pdss_pkg::OSC_KHZ);
                    if (rem >= 64'(pdss_pkg::HALF_OSC))
                        continue;
                    res.found         = 1'b1;
                    res.post_div_code = 4'(d / 2 - 1);
                    res.ref_div_p     = 6'(p);
                    res.mult_m        = mult[9:0];
                    res.shift_s       = 3'(s);
                    res.frac_k        = 15'((rem * FRAC_SCALE) / 64'(pdss_pkg::OSC_KHZ));
                    return res;
                end
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pll_setting want;
        t_pll_setting got;
        if (i_rst_n) begin
            // retire the oldest item first: a result never belongs to the item taken this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.found         = m_axis_tdata[0];
                got.post_div_code = m_axis_tdata[4:1];
                got.ref_div_p     = m_axis_tdata[10:5];
                got.mult_m        = m_axis_tdata[20:11];
                got.shift_s       = m_axis_tdata[23:21];
                got.frac_k        = m_axis_tdata[38:24];
                if (setting_q.size() == 0) begin
                    $error("result with no search pending: tdata %h", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = setting_q.pop_front();
                    compare_field("found", want.found, got.found);
                    compare_field("post_div_code", want.post_div_code, got.post_div_code);
                    compare_field("ref_div_p", want.ref_div_p, got.ref_div_p);
                    compare_field("mult_m", want.mult_m, got.mult_m);
                    compare_field("shift_s", want.shift_s, got.shift_s);
                    compare_field("frac_k", want.frac_k, got.frac_k);
                    o_checked++;
                    if (want.found)
                        o_found++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                setting_q.push_back(search_pll_setting(s_axis_tdata));
            o_pending = setting_q.size();
        end
    end

endmodule

// ----- test/pll_divider_setting_search_core_test.sv -----
// Top of the PLL setting search testbench: clock, reset, rate stimulus and verdict.
`timescale 1ns / 1ps

module pll_divider_setting_search_core_test;

    localparam int RANDOM_RATES = 80;
    localparam int DRAIN_CYCLES = 800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] target_rate_hz
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [0] found, [4:1] post_div_code, [10:5] ref_div_p,
                                       // [20:11] mult_m, [23:21] shift_s, [38:24] frac_k
    int          fail_count;
    int          pending;
    int          checked;
    int          found;

    pll_divider_setting_search_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pll_divider_setting_search_core_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_found       (found)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver pacing: one long hold-off early on, then random stalls with idle-free stretches.
    initial begin : result_pacing
        int cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 200 && cyc < 3200)
                m_axis_tready <= 1'b0;
            else if ((cyc / 500) % 4 == 3)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 17);
        end
    end

    task automatic send_rate(input logic [31:0] rate_hz, input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < 17) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rate_hz;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_rate();
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 55)
            return $urandom_range(216_000_000, 782_000);
        else if (mode < 70)
            return $urandom_range(215_999, 782) * 1000;  // whole kHz
        else if (mode < 85)
            return $urandom;
        else
            return $urandom_range(782_000, 0);
    endfunction

    initial begin : stimulus
        logic [31:0] directed_rates[$];
        directed_rates = '{
            32'd0, 32'd1, 32'd999, 32'd1000,
            32'd781_999, 32'd782_000,                    // output minimum at post divider 32
            32'd12_499_999, 32'd12_500_000,              // output minimum at divider 2
            32'd25_000_000, 32'd33_333_333, 32'd48_000_000,
            32'd100_000_000, 32'd148_500_000, 32'd200_000_000,
            32'd215_000_000, 32'd215_000_999, 32'd215_001_000,  // output maximum
            32'd430_000_000, 32'h8000_0000, 32'h5555_5555,
            32'hAAAA_AAAA, 32'hFFFF_FFFF
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rates[i])
            send_rate(directed_rates[i], 1'b1);
        for (int i = 0; i < RANDOM_RATES; i++)
            send_rate(pick_rate(), !(i >= 40 && i < 65));
        s_axis_tvalid <= 1'b0;

        // let the scoreboard take the last item before polling it
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Searched %0d rates (%0d directed, %0d random): %0d settings found, %0d none.",
                 checked, directed_rates.size(), RANDOM_RATES, found, checked - found);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
